[hdl/atrc_pkg.sv]
package atrc_pkg;

	localparam int PAT_COUNT = 4;
	localparam int WIN_CELLS = 8;

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// pattern text, last character in the low byte
	localparam logic [71:0] PAT_TEXT_OK = "OK\r\n";
	localparam logic [71:0] PAT_TEXT_ERROR = "ERROR\r\n";
	localparam logic [71:0] PAT_TEXT_BUSY = "busy p...";
	localparam logic [71:0] PAT_TEXT_READY = "ready\r\n";

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ACK_NONE  = 3'd0,
		ACK_OK    = 3'd1,
		ACK_ERROR = 3'd2,
		ACK_BUSY  = 3'd3,
		ACK_READY = 3'd4
	} ack_t;

	typedef enum logic [1:0] {
		CAUSE_MATCH   = 2'd0,
		CAUSE_TIMEOUT = 2'd1,
		CAUSE_FULL    = 2'd2
	} cause_t;

	typedef struct packed {
		ack_t   ack_code;
		cause_t end_cause;
	} result_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [3:0] pat_len(input logic [1:0] p);
		logic [3:0] len;
		case (p)
			2'd0:    len = 4'd4;
			2'd1:    len = 4'd7;
			2'd2:    len = 4'd9;
			default: len = 4'd7;
		endcase
		return len;
	endfunction

	// character expected at distance back from the newest byte
	function automatic logic [7:0] pat_char(input logic [1:0] p, input logic [3:0] back);
		logic [71:0] text;
		case (p)
			2'd0:    text = PAT_TEXT_OK;
			2'd1:    text = PAT_TEXT_ERROR;
			2'd2:    text = PAT_TEXT_BUSY;
			default: text = PAT_TEXT_READY;
		endcase
		return text[8*back +: 8];
	endfunction

	function automatic logic pat_care(input logic [1:0] p, input logic [3:0] back);
		return back < pat_len(p);
	endfunction

endpackage

[hdl/atrc_cell.sv]
module atrc_cell (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  atrc_pkg::cell_ctrl_t                            ctrl,
	input  logic [7:0]                                      din,
	input  logic [atrc_pkg::PAT_COUNT-1:0][7:0]             exp_char,
	input  logic [atrc_pkg::PAT_COUNT-1:0]                  exp_care,
	output logic [7:0]                                      dout,
	output logic [atrc_pkg::PAT_COUNT-1:0]                  hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// a position beyond the pattern length always agrees
	always_comb begin
		for (int p = 0; p < atrc_pkg::PAT_COUNT; p++) begin
			hit[p] = !exp_care[p] || (byte_q == exp_char[p]);
		end
	end

endmodule

[hdl/atrc_out_buf.sv]
module atrc_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  atrc_pkg::result_t   din,
	output logic                room,
	output logic                m_tvalid,
	input  logic                m_tready,
	output atrc_pkg::result_t   head
);

	atrc_pkg::result_t head_q;
	atrc_pkg::result_t skid_q;
	logic              head_valid_q;
	logic              skid_valid_q;
	logic              pop;

	assign pop = head_valid_q && m_tready;
	assign room = !skid_valid_q;
	assign m_tvalid = head_valid_q;
	assign head = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (!head_valid_q) begin
			head_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (!head_valid_q) begin
			if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

endmodule

[hdl/at_response_classifier_unit.sv]
// Classifies a modem reply stream. A start transaction clears the wait state
// and loads the millisecond limit; byte transactions shift through a row of
// eight byte cells so that each new byte is compared against the OK, ERROR,
// busy and ready patterns in the same cycle, and a newline reports the seen
// pattern first in the order OK, ERROR, busy, ready. Tick transactions count
// elapsed time against the limit, and a full buffer of BUFFER_BYTES-1 bytes
// ends the wait with code none. One transaction is accepted every clock cycle;
// its result, if any, is presented on the master side from an output register
// backed by a one-entry skid stage; input stalls only when both are occupied.
module at_response_classifier_unit #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] mode, [9:2] data_byte, [25:10] timeout_ms, [31:26] zero
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] ack_code, [4:3] end_cause, [7:5] zero
	output logic [7:0]  m_tdata
);

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam logic [CW-1:0] FULL_COUNT = CW'(BUFFER_BYTES - 1);
	localparam int NP = atrc_pkg::PAT_COUNT;
	localparam int NC = atrc_pkg::WIN_CELLS;

	logic [1:0]  in_mode;
	logic [7:0]  in_byte;
	logic [15:0] in_timeout;
	logic        accept;

	logic          waiting_q;
	logic          text_ended_q;
	logic [NP-1:0] seen_q;
	logic [CW-1:0] count_q;
	logic [15:0]   elapsed_q;
	logic [15:0]   limit_q;

	atrc_pkg::cell_ctrl_t        cell_ctrl;
	logic [NC-1:0][7:0]          cell_byte;
	logic [NC-1:0][NP-1:0][7:0]  cell_exp;
	logic [NC-1:0][NP-1:0]       cell_care;
	logic [NC-1:0][NP-1:0]       cell_hit;

	logic          waiting_n;
	logic          text_ended_n;
	logic [NP-1:0] seen_n;
	logic [NP-1:0] match;
	logic [CW-1:0] count_n;
	logic [15:0]   elapsed_n;
	logic          res_push;
	atrc_pkg::result_t res;
	atrc_pkg::result_t head;
	logic          room;

	assign in_mode = s_tdata[1:0];
	assign in_byte = s_tdata[9:2];
	assign in_timeout = s_tdata[25:10];
	assign s_tready = room;
	assign accept = s_tvalid && s_tready;

	// newest cell receives the incoming byte, the rest take their neighbor's
	genvar k, p;
	generate
		for (k = 0; k < NC; k++) begin : g_cell
			for (p = 0; p < NP; p++) begin : g_pat
				assign cell_exp[k][p] = atrc_pkg::pat_char(2'(p), 4'(k + 1));
				assign cell_care[k][p] = atrc_pkg::pat_care(2'(p), 4'(k + 1));
			end
			atrc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.din      ((k == 0) ? in_byte : cell_byte[(k == 0) ? 0 : k - 1]),
				.exp_char (cell_exp[k]),
				.exp_care (cell_care[k]),
				.dout     (cell_byte[k]),
				.hit      (cell_hit[k])
			);
		end
	endgenerate

	always_comb begin
		logic all_hit;
		for (int i = 0; i < NP; i++) begin
			all_hit = (in_byte == atrc_pkg::pat_char(2'(i), 4'd0));
			for (int j = 0; j < NC; j++) begin
				all_hit = all_hit && cell_hit[j][i];
			end
			match[i] = all_hit;
		end
	end

	always_comb begin
		cell_ctrl = '0;
		waiting_n = waiting_q;
		text_ended_n = text_ended_q;
		seen_n = seen_q;
		count_n = count_q;
		elapsed_n = elapsed_q;
		res_push = 1'b0;
		res.ack_code = atrc_pkg::ACK_NONE;
		res.end_cause = atrc_pkg::CAUSE_MATCH;
		if (accept) begin
			case (in_mode)
				atrc_pkg::MODE_START: begin
					cell_ctrl.clear = 1'b1;
					waiting_n = 1'b1;
					text_ended_n = 1'b0;
					seen_n = '0;
					count_n = '0;
					elapsed_n = '0;
				end
				atrc_pkg::MODE_BYTE: begin
					if (waiting_q) begin
						cell_ctrl.shift = 1'b1;
						text_ended_n = text_ended_q || (in_byte == atrc_pkg::CHAR_NUL);
						if (!text_ended_n) begin
							seen_n = seen_q | match;
						end
						count_n = count_q + 1'b1;
						if (in_byte == atrc_pkg::CHAR_NL && seen_n != '0) begin
							res_push = 1'b1;
							waiting_n = 1'b0;
							if (seen_n[0]) begin
								res.ack_code = atrc_pkg::ACK_OK;
							end else if (seen_n[1]) begin
								res.ack_code = atrc_pkg::ACK_ERROR;
							end else if (seen_n[2]) begin
								res.ack_code = atrc_pkg::ACK_BUSY;
							end else begin
								res.ack_code = atrc_pkg::ACK_READY;
							end
						end else if (count_n == FULL_COUNT) begin
							res_push = 1'b1;
							waiting_n = 1'b0;
							res.end_cause = atrc_pkg::CAUSE_FULL;
						end
					end
				end
				atrc_pkg::MODE_TICK: begin
					if (waiting_q) begin
						if (elapsed_q != 16'hFFFF) begin
							elapsed_n = elapsed_q + 16'd1;
						end
						if (elapsed_n >= limit_q) begin
							res_push = 1'b1;
							waiting_n = 1'b0;
							res.end_cause = atrc_pkg::CAUSE_TIMEOUT;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			text_ended_q <= 1'b0;
			seen_q <= '0;
			count_q <= '0;
			elapsed_q <= '0;
			limit_q <= '0;
		end else begin
			waiting_q <= waiting_n;
			text_ended_q <= text_ended_n;
			seen_q <= seen_n;
			count_q <= count_n;
			elapsed_q <= elapsed_n;
			if (accept && in_mode == atrc_pkg::MODE_START) begin
				limit_q <= in_timeout;
			end
		end
	end

	atrc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.din      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {3'b000, head.end_cause, head.ack_code};

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_timeout_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:3] == atrc_pkg::CAUSE_TIMEOUT |-> m_tdata[2:0] == atrc_pkg::ACK_NONE)
		else $error("timeout result carries a pattern code");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_mode == atrc_pkg::MODE_START |=> waiting_q && count_q == '0 && seen_q == '0)
		else $error("start did not open a cleared wait");

	a_result_ends_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !(accept && in_mode == atrc_pkg::MODE_START) |=> !waiting_q)
		else $error("wait still open after a result");

endmodule

[tb/tb_at_response_classifier_unit.sv]
`timescale 1ns / 100ps

module tb_at_response_classifier_unit;
	import atrc_pkg::*;

	localparam int BUF_BYTES = 2048;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// Tracks the wait state of the classifier and queues the acks it must report.
	class ack_tracker;
		result_t pending_acks[$];
		bit waiting;
		logic [63:0] window;
		logic [3:0] seen;
		bit text_done;
		int unsigned byte_cnt;
		logic [15:0] elapsed;
		logic [15:0] limit;
		int unsigned errors;
		int unsigned live_items;
		int unsigned buf_bytes;

		function new(int unsigned bytes);
			buf_bytes = bytes;
			errors = 0;
			live_items = 0;
			clear_wait();
		endfunction

		static function logic [71:0] pattern(int p);
			case (p)
				0: return PAT_TEXT_OK;
				1: return PAT_TEXT_ERROR;
				2: return PAT_TEXT_BUSY;
				default: return PAT_TEXT_READY;
			endcase
		endfunction

		static function int pattern_len(int p);
			case (p)
				0: return 4;
				1: return 7;
				2: return 9;
				default: return 7;
			endcase
		endfunction

		function void clear_wait();
			waiting = 1'b0;
			window = '0;
			seen = '0;
			text_done = 1'b0;
			byte_cnt = 0;
			elapsed = '0;
			limit = '0;
		endfunction

		function void end_wait(ack_t code, cause_t cause);
			result_t r;
			r.ack_code = code;
			r.end_cause = cause;
			pending_acks.push_back(r);
			waiting = 1'b0;
		endfunction

		function void take_item(logic [31:0] d);
			logic [1:0] md;
			logic [7:0] ch;
			logic [71:0] text;
			logic [71:0] mask;
			bit found;
			md = d[1:0];
			ch = d[9:2];
			if (md == MODE_START) begin
				clear_wait();
				limit = d[25:10];
				waiting = 1'b1;
				live_items++;
				return;
			end
			if (!waiting || md == MODE_SPARE)
				return;
			live_items++;
			if (md == MODE_BYTE) begin
				if (ch == CHAR_NUL)
					text_done = 1'b1;
				if (!text_done) begin
					text = {window, ch};
					for (int p = 0; p < PAT_COUNT; p++) begin
						mask = (72'd1 << (8 * pattern_len(p))) - 72'd1;
						if (((text ^ pattern(p)) & mask) == '0)
							seen[p] = 1'b1;
					end
				end
				window = {window[55:0], ch};
				byte_cnt++;
				found = 1'b0;
				if (ch == CHAR_NL) begin
					// first flagged pattern in table order wins
					for (int p = 0; p < PAT_COUNT; p++) begin
						if (!found && seen[p]) begin
							found = 1'b1;
							end_wait(ack_t'(p + 1), CAUSE_MATCH);
						end
					end
				end
				if (!found && byte_cnt >= buf_bytes - 1)
					end_wait(ACK_NONE, CAUSE_FULL);
			end else begin
				if (elapsed != 16'hFFFF)
					elapsed++;
				if (elapsed >= limit)
					end_wait(ACK_NONE, CAUSE_TIMEOUT);
			end
		endfunction

		function void check_ack(logic [7:0] d);
			result_t want;
			if (pending_acks.size() == 0) begin
				$display("%0t: unexpected result ack_code %0d end_cause %0d",
					$time, d[2:0], d[4:3]);
				errors++;
				return;
			end
			want = pending_acks.pop_front();
			if (d[2:0] != want.ack_code) begin
				$display("%0t: ack_code expected %0d actual %0d",
					$time, want.ack_code, d[2:0]);
				errors++;
			end
			if (d[4:3] != want.end_cause) begin
				$display("%0t: end_cause expected %0d actual %0d",
					$time, want.end_cause, d[4:3]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	ack_tracker tracker = new(BUF_BYTES);

	at_response_classifier_unit #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.check_ack(m_tdata);
			if (s_tvalid && s_tready)
				tracker.take_item(s_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_at_response_classifier_unit: errors");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] md, input logic [7:0] ch,
			input logic [15:0] tmo);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, tmo, ch, md};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic put_start(input logic [15:0] tmo);
		send_item(MODE_START, 8'($urandom_range(255)), tmo);
	endtask

	task automatic put_byte(input logic [7:0] ch);
		send_item(MODE_BYTE, ch, 16'($urandom_range(65535)));
	endtask

	task automatic put_tick();
		send_item(MODE_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)));
	endtask

	task automatic put_noise();
		send_item(MODE_SPARE, 8'($urandom_range(255)), 16'($urandom_range(65535)));
	endtask

	// send the first n characters of a pattern, oldest first
	task automatic put_text(input int p, input int n);
		logic [71:0] text;
		int len;
		text = ack_tracker::pattern(p);
		len = ack_tracker::pattern_len(p);
		for (int i = 0; i < n; i++)
			put_byte(text[8 * (len - 1 - i) +: 8]);
	endtask

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'($urandom_range(65535));
			2: return 16'hFFFF;
			default: return 16'($urandom_range(1, 24));
		endcase
	endfunction

	task automatic run_wait();
		int chunks;
		int p;
		int n;
		put_start(pick_limit());
		chunks = $urandom_range(1, 8);
		repeat (chunks) begin
			case ($urandom_range(11))
				0, 1, 2, 3, 4: begin
					p = $urandom_range(PAT_COUNT - 1);
					n = ack_tracker::pattern_len(p);
					if ($urandom_range(3) == 0)
						n = $urandom_range(1, n);
					put_text(p, n);
				end
				5: begin
					put_byte(CHAR_CR);
					put_byte(CHAR_NL);
				end
				6: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(32, 126)));
				7: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
				8: repeat ($urandom_range(1, 3)) put_tick();
				9: put_byte(($urandom_range(4) == 0) ? CHAR_NUL : CHAR_NL);
				10: put_noise();
				default: put_start(pick_limit());
			endcase
		end
	endtask

	// fill the buffer; optionally flag busy early and let a newline land on the last slot
	task automatic fill_buffer(input bit end_on_match);
		int count;
		put_start(16'hFFFF);
		count = 0;
		if (end_on_match) begin
			put_text(2, 9);
			count = 9;
		end
		while (count < BUF_BYTES - 2) begin
			put_byte((count == 1000) ? CHAR_NUL : 8'($urandom_range(11, 255)));
			count++;
		end
		put_byte(end_on_match ? CHAR_NL : 8'h41);
	endtask

	initial begin
		int goal;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle items are dropped
		put_byte(8'h78);
		put_tick();
		put_noise();
		// zero limit times out on the first tick
		put_start(16'h0000);
		put_tick();
		put_start(16'hFFFF);
		put_text(0, 4);
		// bare newline gives nothing, then the limit runs out
		put_start(16'd2);
		put_byte(CHAR_NL);
		put_tick();
		put_tick();
		// text after a zero byte sets no flag
		put_start(16'd500);
		put_byte(CHAR_NUL);
		put_text(0, 4);
		// restart in the middle of a wait
		put_start(16'd7);
		put_byte(8'hFF);
		put_noise();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 79;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 79;
				end
				default: begin
					idle_pct = 28;
					stall_pct = 28;
				end
			endcase
			goal = tracker.live_items + 100;
			while (tracker.live_items < goal)
				run_wait();
			if (phase == 0) begin
				fill_buffer(1'b0);
			end
		end

		s_tvalid <= 1'b0;
		while (tracker.pending_acks.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_at_response_classifier_unit: clean");
		else
			$display("tb_at_response_classifier_unit: errors");
		$finish;
	end

endmodule
